/* rtl/spp_pkg.sv */
// Shared types, constants and register indexes for the speed profile planner.
package spp_pkg;

  localparam int MaxPointsDefault  = 64;
  localparam int QueueDepthDefault = 4;

  typedef struct packed {
    logic [23:0]        arc_length;
    logic signed [15:0] curvature;
    logic               final_point;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  point_index;
    logic [15:0] reference_speed;
    logic        error_flag;
    logic        last_result;
  } out_item_t;

  typedef enum logic [2:0] {
    REG_LAT_ACCEL   = 3'd0,
    REG_TOP_SPEED   = 3'd1,
    REG_START_SPEED = 3'd2,
    REG_GOAL_SPEED  = 3'd3,
    REG_FLOOR_SPEED = 3'd4,
    REG_FWD_ACCEL   = 3'd5,
    REG_BRAKE_DECEL = 3'd6,
    REG_CURV_FLOOR  = 3'd7
  } reg_index_t;

  // front-to-back queue entry: one classified point
  typedef struct packed {
    logic [23:0] arc_length;
    logic [15:0] curv_mag;   // magnitude after floor, never zero
    logic        final_point;
  } point_t;

endpackage

/* rtl/spp_root.sv */
// Iterative unit: 64-by-16 divide (one bit per cycle) and 64-bit floor square root.
module spp_root (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        div_mode,   // 1: root(num / den), 0: root(num)
  input  logic [63:0] num,
  input  logic [15:0] den,
  output logic        busy,
  output logic        done,
  output logic [31:0] root
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_SQRT = 3'b100
  } state_t;

  state_t      state;
  logic [63:0] x;
  logic [16:0] rem;
  logic [5:0]  cnt;
  logic [31:0] res;
  logic [33:0] srem;
  logic [16:0] rem_shift;
  logic [33:0] trial;
  logic [33:0] srem_shift;

  always_comb begin
    rem_shift  = {rem[15:0], x[63]};
    srem_shift = {srem[31:0], x[63:62]};
    trial      = {res, 2'b01};
  end

  assign busy = (state != ST_IDLE);
  assign root = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            x    <= num;
            rem  <= '0;
            srem <= '0;
            res  <= '0;
            cnt  <= '0;
            state <= div_mode ? ST_DIV : ST_SQRT;
          end
        end
        ST_DIV: begin
          // restoring division, quotient bits shift into x
          if (rem_shift >= {1'b0, den}) begin
            rem <= rem_shift - {1'b0, den};
            x   <= {x[62:0], 1'b1};
          end else begin
            rem <= rem_shift;
            x   <= {x[62:0], 1'b0};
          end
          cnt <= cnt + 6'd1;
          if (cnt == 6'd63) begin
            cnt   <= '0;
            state <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          // two radicand bits per step
          x <= {x[61:0], 2'b00};
          if (srem_shift >= trial) begin
            srem <= srem_shift - trial;
            res  <= {res[30:0], 1'b1};
          end else begin
            srem <= srem_shift;
            res  <= {res[30:0], 1'b0};
          end
          cnt <= cnt + 6'd1;
          if (cnt == 6'd31) begin
            state <= ST_IDLE;
            done  <= 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

/* rtl/spp_front.sv */
// Front end: accepts points, folds curvature to its floored magnitude, queues them.
module spp_front #(
  parameter int Depth = spp_pkg::QueueDepthDefault
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  spp_pkg::in_item_t in_item,
  input  logic [14:0]      curv_floor,
  output logic             q_valid,
  input  logic             q_ready,
  output spp_pkg::point_t  q_item
);

  localparam int AW = $clog2(Depth);

  spp_pkg::point_t queue [Depth];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   fill;
  logic [15:0]   mag;
  logic [15:0]   mag_fl;
  logic          push;
  logic          pop;

  always_comb begin
    mag    = in_item.curvature[15] ? 16'(-in_item.curvature) : in_item.curvature;
    mag_fl = (mag < {1'b0, curv_floor}) ? {1'b0, curv_floor} : mag;
    if (mag_fl == 16'd0) mag_fl = 16'd1;
  end

  assign in_ready = (fill != AW'(0) + (AW+1)'(Depth));
  assign push     = in_valid && in_ready;
  assign q_valid  = (fill != '0);
  assign pop      = q_valid && q_ready;
  assign q_item   = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= '{arc_length: in_item.arc_length, curv_mag: mag_fl,
                         final_point: in_item.final_point};
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + AW'(1);
      if (pop)  rd_ptr <= rd_ptr + AW'(1);
      fill <= fill + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

/* rtl/spp_back.sv */
// Back end: curvature limits, forward and backward passes, result emission.
module spp_back #(
  parameter int MaxPoints = spp_pkg::MaxPointsDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  output logic              q_ready,
  input  spp_pkg::point_t   q_item,
  input  logic [15:0]       lat_accel,
  input  logic [15:0]       top_speed,
  input  logic [15:0]       start_speed,
  input  logic [15:0]       goal_speed,
  input  logic [15:0]       floor_speed,
  input  logic [15:0]       fwd_accel,
  input  logic [15:0]       brake_decel,
  output logic              out_valid,
  input  logic              out_ready,
  output spp_pkg::out_item_t out_item
);

  localparam int IW = $clog2(MaxPoints);
  localparam int CW = $clog2(MaxPoints + 1);

  typedef enum logic [10:0] {
    S_TAKE   = 11'b00000000001,
    S_LIMIT  = 11'b00000000010,
    S_FRD    = 11'b00000000100,
    S_FCALC  = 11'b00000001000,
    S_FWAIT  = 11'b00000010000,
    S_BRD    = 11'b00000100000,
    S_BCALC  = 11'b00001000000,
    S_BWAIT  = 11'b00010000000,
    S_ORD    = 11'b00100000000,
    S_OUT    = 11'b01000000000,
    S_ERR    = 11'b10000000000
  } state_t;

  state_t state;
  logic [23:0] dist_mem [MaxPoints];
  logic [15:0] speed_mem [MaxPoints];
  logic [CW-1:0] count;
  logic [CW-1:0] n;
  logic [IW-1:0] idx;
  logic          last_take;
  logic [23:0]   d_lo, d_hi;
  logic [15:0]   v_src, v_dst;
  logic [15:0]   v_new;
  logic [31:0]   vsq;
  logic [47:0]   ad;
  logic [24:0]   ddiff;

  logic        rt_start, rt_div, rt_busy, rt_done;
  logic [63:0] rt_num;
  logic [31:0] rt_root;
  logic [15:0] rt_den;

  spp_root u_root (
    .clk(clk), .rst(rst), .start(rt_start), .div_mode(rt_div),
    .num(rt_num), .den(rt_den), .busy(rt_busy), .done(rt_done), .root(rt_root)
  );

  logic [15:0] cap_lim;
  logic [15:0] reach_v;
  always_comb begin
    cap_lim = (rt_root > {16'd0, top_speed}) ? top_speed : rt_root[15:0];
    reach_v = (rt_root > 32'h0000FFFF) ? 16'hFFFF : rt_root[15:0];
    v_new   = (reach_v < v_dst) ? reach_v : v_dst;
    ddiff   = {1'b0, d_hi} - {1'b0, d_lo};
  end

  assign q_ready = (state == S_TAKE) && !rt_busy;
  assign out_valid = (state == S_OUT) || (state == S_ERR);

  always_ff @(posedge clk) begin
    rt_start <= 1'b0;
    if (rst) begin
      state <= S_TAKE;
      count <= '0;
    end else begin
      unique case (state)
        S_TAKE: begin
          if (q_valid && q_ready) begin
            last_take <= q_item.final_point;
            if (count < CW'(MaxPoints)) begin
              dist_mem[count[IW-1:0]] <= q_item.arc_length;
              idx      <= count[IW-1:0];
              rt_num   <= {24'd0, lat_accel, 24'd0} >> 4;
              rt_den   <= q_item.curv_mag;
              rt_div   <= 1'b1;
              rt_start <= 1'b1;
              count    <= count + CW'(1);
              state    <= S_LIMIT;
            end else if (q_item.final_point) begin
              n <= count; count <= '0; state <= S_FRD; idx <= IW'(1);
              speed_mem[0] <= start_speed;
            end
          end
        end
        S_LIMIT: begin
          if (rt_done) begin
            speed_mem[idx] <= cap_lim;
            if (!last_take) state <= S_TAKE;
            else begin
              n <= count;
              count <= '0;
              if (count < CW'(2)) state <= S_ERR;
              else begin
                speed_mem[0] <= start_speed;
                idx   <= IW'(1);
                state <= S_FRD;
              end
            end
          end
        end
        // forward pass: idx is the point being limited
        S_FRD: begin
          d_hi  <= dist_mem[idx];
          d_lo  <= dist_mem[idx - IW'(1)];
          v_src <= speed_mem[idx - IW'(1)];
          v_dst <= speed_mem[idx];
          state <= S_FCALC;
        end
        S_FCALC: begin
          vsq <= v_src * v_src;
          ad  <= fwd_accel * ddiff[23:0];
          if (ddiff[24] || ddiff == '0) begin
            if ({1'b0, idx} == CW'(n - CW'(1))) begin
              speed_mem[idx] <= goal_speed; state <= S_BRD;
            end else begin
              idx <= idx + IW'(1); state <= S_FRD;
            end
          end else state <= S_FWAIT;
        end
        S_FWAIT: begin
          if (!rt_busy && !rt_start && !rt_done) begin
            rt_num   <= {32'd0, vsq} + {15'd0, ad, 1'b0};
            rt_div   <= 1'b0;
            rt_start <= 1'b1;
          end
          if (rt_done) begin
            if ({1'b0, idx} == CW'(n - CW'(1))) begin
              speed_mem[idx] <= goal_speed; state <= S_BRD;
            end else begin
              speed_mem[idx] <= v_new;
              idx <= idx + IW'(1); state <= S_FRD;
            end
          end
        end
        // backward pass: idx is the upper point of the pair
        S_BRD: begin
          d_hi  <= dist_mem[idx];
          d_lo  <= dist_mem[idx - IW'(1)];
          v_src <= speed_mem[idx];
          v_dst <= speed_mem[idx - IW'(1)];
          state <= S_BCALC;
        end
        S_BCALC: begin
          vsq <= v_src * v_src;
          ad  <= brake_decel * ddiff[23:0];
          if (ddiff[24] || ddiff == '0) begin
            if (idx == IW'(1)) begin idx <= '0; state <= S_ORD; end
            else begin idx <= idx - IW'(1); state <= S_BRD; end
          end else state <= S_BWAIT;
        end
        S_BWAIT: begin
          if (!rt_busy && !rt_start && !rt_done) begin
            rt_num   <= {32'd0, vsq} + {15'd0, ad, 1'b0};
            rt_div   <= 1'b0;
            rt_start <= 1'b1;
          end
          if (rt_done) begin
            if (reach_v < v_dst) speed_mem[idx - IW'(1)] <= reach_v;
            if (idx == IW'(1)) begin idx <= '0; state <= S_ORD; end
            else begin idx <= idx - IW'(1); state <= S_BRD; end
          end
        end
        S_ORD: begin
          v_src <= speed_mem[idx];
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            if ({1'b0, idx} == CW'(n - CW'(1))) state <= S_TAKE;
            else begin idx <= idx + IW'(1); state <= S_ORD; end
          end
        end
        S_ERR: begin
          if (out_ready) state <= S_TAKE;
        end
        default: state <= S_TAKE;
      endcase
    end
  end

  logic is_last;
  always_comb begin
    is_last = ({1'b0, idx} == CW'(n - CW'(1)));
    out_item = '0;
    if (state == S_ERR) begin
      out_item.error_flag  = 1'b1;
      out_item.last_result = 1'b1;
    end else begin
      out_item.point_index     = 6'(idx);
      out_item.reference_speed = (!is_last && v_src < floor_speed) ? floor_speed : v_src;
      out_item.last_result     = is_last;
    end
  end

endmodule

/* rtl/path_speed_profile_planner_unit.sv */
// Top level of the path speed profile planner.
// Points enter on the in channel (valid/ready), one request per path point;
// final_point closes the path. A front queue takes points while the back end
// computes each point's curvature limit with a shared divide/root unit
// (64 divide steps plus 32 root steps), and takes the next point only once
// the current point's limit is done.
// On the final point the back end runs a forward then a backward pass over
// the stored points, using the root unit for each pair except a pair without
// positive spacing, then emits one result per point on the out channel, in
// order, the last flagged; each is read in S_ORD, then offered in S_OUT.
// A path of fewer than two points yields one error result.
// Results wait in place while out_ready is low; the front queue keeps taking
// points until it fills. Reset (rst, synchronous) restores register defaults,
// empties the queue and clears the point count; stores need no clearing.
// Registers are to be written through cfg_we/cfg_index/cfg_data while idle; the block does not enforce it.
module path_speed_profile_planner_unit #(
  parameter int MaxPoints  = spp_pkg::MaxPointsDefault,
  parameter int QueueDepth = spp_pkg::QueueDepthDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  spp_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output spp_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  logic [15:0] lat_accel, top_speed, start_speed, goal_speed;
  logic [15:0] floor_speed, fwd_accel, brake_decel;
  logic [14:0] curv_floor;

  always_ff @(posedge clk) begin
    if (rst) begin
      lat_accel   <= 16'd128;
      top_speed   <= 16'd256;
      start_speed <= 16'd0;
      goal_speed  <= 16'd0;
      floor_speed <= 16'd26;
      fwd_accel   <= 16'd128;
      brake_decel <= 16'd128;
      curv_floor  <= 15'd41;
    end else if (cfg_we) begin
      unique case (spp_pkg::reg_index_t'(cfg_index))
        spp_pkg::REG_LAT_ACCEL:   lat_accel   <= cfg_data;
        spp_pkg::REG_TOP_SPEED:   top_speed   <= cfg_data;
        spp_pkg::REG_START_SPEED: start_speed <= cfg_data;
        spp_pkg::REG_GOAL_SPEED:  goal_speed  <= cfg_data;
        spp_pkg::REG_FLOOR_SPEED: floor_speed <= cfg_data;
        spp_pkg::REG_FWD_ACCEL:   fwd_accel   <= cfg_data;
        spp_pkg::REG_BRAKE_DECEL: brake_decel <= cfg_data;
        spp_pkg::REG_CURV_FLOOR:  curv_floor  <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  logic            q_valid, q_ready;
  spp_pkg::point_t q_item;

  spp_front #(.Depth(QueueDepth)) u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_item(in_item), .curv_floor(curv_floor),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
  );

  spp_back #(.MaxPoints(MaxPoints)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
    .lat_accel(lat_accel), .top_speed(top_speed), .start_speed(start_speed),
    .goal_speed(goal_speed), .floor_speed(floor_speed), .fwd_accel(fwd_accel),
    .brake_decel(brake_decel), .out_valid(out_valid), .out_ready(out_ready),
    .out_item(out_item)
  );

endmodule
